// ===== rtl/core/mglr_pkg.sv =====
package mglr_pkg;

	// Command codes carried on the op port.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SOLVE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_TOL    = 2'd0;
	localparam logic [1:0] REG_COARSE = 2'd1;
	localparam logic [1:0] REG_MAXSW  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [39:0] TOL_RST    = 40'd10995;
	localparam logic [2:0]  COARSE_RST = 3'd4;
	localparam logic [15:0] MAXSW_RST  = 16'd65535;

	// Saturation value of the energy and of the sweep total.
	localparam logic [47:0] E48_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [19:0] SW_MAX  = 20'hFFFFF;

	// Shared multiplier: a wide operand times a 17-bit digit.
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

// ===== rtl/core/multigrid_laplace_relaxation.sv =====
// A node write, a node read or an unknown command gives its result in the cycle after its
// transfer, and such commands are taken one per cycle. A solve holds busy until its result;
// its sweeps, energy sums and refinement share the one grid memory read port and the shared
// multiplier.
// After reset a clearing pass writes zero to all (GRID_CELLS+1)^2 nodes, one per cycle,
// with busy high. Results are strobed on done for one cycle; the receiver cannot stall.
module multigrid_laplace_relaxation #(
	parameter int GRID_CELLS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic signed [31:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	output logic        done,
	output logic signed [31:0] node_value,
	output logic [19:0] sweep_count,
	output logic [47:0] energy,
	output logic        converged
);
	import mglr_pkg::*;

	// Grid geometry. Coordinates must also hold a node index plus the largest step.
	localparam int NODES = GRID_CELLS + 1;
	localparam int DEPTH = NODES * NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(GRID_CELLS + 129);
	localparam logic [CW:0] G_C = (CW+1)'(GRID_CELLS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	// The energy accumulator holds two squares of at most 2^66 for every cell.
	localparam int ACC_W = 68 + 2 * $clog2(GRID_CELLS + 1);

	typedef enum logic [14:0] {
		S_CLEAR    = 15'b000000000000001,
		S_IDLE     = 15'b000000000000010,
		S_LEVEL    = 15'b000000000000100,
		S_SW_BEGIN = 15'b000000000001000,
		S_SW_FETCH = 15'b000000000010000,
		S_SW_PUT   = 15'b000000000100000,
		S_EN_START = 15'b000000001000000,
		S_EN_FETCH = 15'b000000010000000,
		S_EN_MUL   = 15'b000000100000000,
		S_EN_FIN   = 15'b000001000000000,
		S_TEST     = 15'b000010000000000,
		S_DECIDE   = 15'b000100000000000,
		S_LVL_END  = 15'b001000000000000,
		S_RF_FETCH = 15'b010000000000000,
		S_RF_PUT   = 15'b100000000000000
	} state_t;

	// Configuration registers.
	logic [39:0] tol_q;
	logic [2:0]  cstep_q;
	logic [15:0] maxsw_q;

	// Sequencer state.
	state_t             state_q;
	logic [2:0]         ph_q;
	logic [2:0]         lev_q;
	logic [7:0]         k_q;
	logic [CW-1:0]      i_q, j_q;
	logic [15:0]        n_q, cap_q;
	logic [47:0]        p_q, s_q;
	logic [ACC_W-1:0]   acc_q;
	logic [87:0]        prod_q;
	logic signed [31:0] c_q [4];
	logic [AW-1:0]      clr_q;

	// Result registers.
	logic [19:0] total_q;
	logic        conv_q;
	logic [47:0] energy_q;
	logic        done_q;
	logic        rdsel_q;

	// Memory and multiplier connections.
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;
	mul_req_t      mreq;
	logic [MUL_P_W-1:0] mul_q;

	function automatic logic [AW-1:0] node_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
		return AW'(AW'(y) * AW'(NODES) + AW'(x));
	endfunction

	// Edge nodes are never changed by the solver.
	function automatic logic interior(input logic [CW-1:0] x, input logic [CW-1:0] y);
		return (x != '0) && (y != '0) && ((CW+1)'(x) < G_C) && ((CW+1)'(y) < G_C);
	endfunction

	logic accept;
	logic host_in;
	assign accept  = start && (state_q == S_IDLE);
	assign host_in = ((CW+1)'(col) <= G_C) && ((CW+1)'(row) <= G_C);

	// Step, half step and the neighbor coordinates used by every pass.
	logic [CW-1:0] kc, hc, ipk, imk, jpk, jmk, iph, jph;
	logic [CW:0]   nx2, ny2, k2;
	assign kc  = CW'(k_q);
	assign hc  = CW'(k_q >> 1);
	assign ipk = i_q + kc;
	assign imk = i_q - kc;
	assign jpk = j_q + kc;
	assign jmk = j_q - kc;
	assign iph = i_q + hc;
	assign jph = j_q + hc;
	assign nx2 = (CW+1)'(ipk) + (CW+1)'(kc);
	assign ny2 = (CW+1)'(jpk) + (CW+1)'(kc);
	assign k2  = (CW+1)'(kc) + (CW+1)'(kc);

	// Means of the fetched corners or neighbors, floored by an arithmetic shift.
	logic signed [33:0] sum4, a_d, b_d;
	logic signed [32:0] s_r, s_t, s_b, s_l;
	logic [33:0]        ma, mb;
	assign sum4 = 34'(c_q[0]) + 34'(c_q[1]) + 34'(c_q[2]) + 34'(c_q[3]);
	assign s_r  = 33'(c_q[1]) + 33'(c_q[3]);
	assign s_t  = 33'(c_q[2]) + 33'(c_q[3]);
	assign s_b  = 33'(c_q[0]) + 33'(c_q[1]);
	assign s_l  = 33'(c_q[0]) + 33'(c_q[2]);
	// Corner order in c_q: lower left, lower right, upper left, upper right.
	assign a_d  = 34'(c_q[1]) - 34'(c_q[0]) + 34'(c_q[3]) - 34'(c_q[2]);
	assign b_d  = 34'(c_q[2]) - 34'(c_q[0]) + 34'(c_q[3]) - 34'(c_q[1]);
	assign ma   = a_d[33] ? 34'(-a_d) : 34'(a_d);
	assign mb   = b_d[33] ? 34'(-b_d) : 34'(b_d);

	// Energy scaling from Q.56 to Q23.25 with saturation, and the tolerance test.
	logic [ACC_W-1:0] acc_sh;
	logic [47:0]      s_next, d_abs;
	logic             pass;
	assign acc_sh = acc_q >> 31;
	assign s_next = (acc_sh > ACC_W'(E48_MAX)) ? E48_MAX : acc_sh[47:0];
	assign d_abs  = (s_q > p_q) ? (s_q - p_q) : (p_q - s_q);
	assign pass   = {d_abs, 40'b0} < prod_q;

	// Memory read address: the neighbor or corner in turn in the fetch states, else the host ports.
	always_comb begin
		mem_raddr = node_addr(CW'(col), CW'(row));
		if (state_q == S_SW_FETCH) begin
			case (ph_q)
				3'd0:    mem_raddr = node_addr(ipk, j_q);
				3'd1:    mem_raddr = node_addr(imk, j_q);
				3'd2:    mem_raddr = node_addr(i_q, jpk);
				default: mem_raddr = node_addr(i_q, jmk);
			endcase
		end else if (state_q == S_EN_FETCH || state_q == S_RF_FETCH) begin
			case (ph_q)
				3'd0:    mem_raddr = node_addr(i_q, j_q);
				3'd1:    mem_raddr = node_addr(ipk, j_q);
				3'd2:    mem_raddr = node_addr(i_q, jpk);
				default: mem_raddr = node_addr(ipk, jpk);
			endcase
		end
	end

	// Memory write port.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_addr(CW'(col), CW'(row));
		mem_wdata = value;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_we = start && (op == OP_WRITE) && host_in;
			end
			S_SW_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = node_addr(i_q, j_q);
				mem_wdata = sum4[33:2];
			end
			S_RF_PUT: begin
				case (ph_q)
					3'd0: begin
						mem_waddr = node_addr(iph, jph);
						mem_wdata = sum4[33:2];
						mem_we    = interior(iph, jph);
					end
					3'd1: begin
						mem_waddr = node_addr(ipk, jph);
						mem_wdata = s_r[32:1];
						mem_we    = interior(ipk, jph);
					end
					3'd2: begin
						mem_waddr = node_addr(iph, jpk);
						mem_wdata = s_t[32:1];
						mem_we    = interior(iph, jpk);
					end
					3'd3: begin
						mem_waddr = node_addr(iph, j_q);
						mem_wdata = s_b[32:1];
						mem_we    = interior(iph, j_q);
					end
					default: begin
						mem_waddr = node_addr(i_q, jph);
						mem_wdata = s_l[32:1];
						mem_we    = interior(i_q, jph);
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Multiplier operands. Each square is two products with a 17-bit digit of the
	// magnitude; tol*Sprev is three products with 17-bit digits of tol.
	always_comb begin
		mreq.a = '0;
		mreq.b = '0;
		if (state_q == S_EN_MUL) begin
			case (ph_q)
				3'd0: begin
					mreq.a = MUL_A_W'(ma);
					mreq.b = ma[16:0];
				end
				3'd1: begin
					mreq.a = MUL_A_W'(ma);
					mreq.b = ma[33:17];
				end
				3'd2: begin
					mreq.a = MUL_A_W'(mb);
					mreq.b = mb[16:0];
				end
				default: begin
					mreq.a = MUL_A_W'(mb);
					mreq.b = mb[33:17];
				end
			endcase
		end else if (state_q == S_TEST) begin
			mreq.a = p_q;
			case (ph_q)
				3'd0:    mreq.b = tol_q[16:0];
				3'd1:    mreq.b = tol_q[33:17];
				default: mreq.b = {11'b0, tol_q[39:34]};
			endcase
		end
	end

	mglr_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	mglr_mul u_mul (
		.clk(clk),
		.req(mreq),
		.prod(mul_q)
	);

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RST;
			cstep_q <= COARSE_RST;
			maxsw_q <= MAXSW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOL:    tol_q   <= cfg_data;
				REG_COARSE: cstep_q <= cfg_data[2:0];
				REG_MAXSW:  maxsw_q <= cfg_data[15:0];
				default:    ;
			endcase
		end
	end

	// The sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			ph_q     <= '0;
			lev_q    <= '0;
			k_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			n_q      <= '0;
			cap_q    <= '0;
			p_q      <= '0;
			s_q      <= '0;
			acc_q    <= '0;
			prod_q   <= '0;
			c_q      <= '{default: '0};
			clr_q    <= '0;
			total_q  <= '0;
			conv_q   <= 1'b0;
			energy_q <= '0;
			done_q   <= 1'b0;
			rdsel_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			// Fetch states capture the word read in the previous cycle.
			if ((state_q == S_SW_FETCH || state_q == S_EN_FETCH || state_q == S_RF_FETCH)
			    && ph_q != 3'd0) begin
				c_q[2'(ph_q - 3'd1)] <= mem_rdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (op == OP_SOLVE) begin
							cap_q   <= (maxsw_q == '0) ? 16'd1 : maxsw_q;
							total_q <= '0;
							conv_q  <= 1'b1;
							lev_q   <= cstep_q;
							state_q <= S_LEVEL;
						end else begin
							done_q  <= 1'b1;
							rdsel_q <= (op == OP_READ) && host_in;
						end
					end
				end
				S_LEVEL: begin
					k_q     <= 8'd1 << lev_q;
					p_q     <= 48'(tol_q >> 12);
					n_q     <= '0;
					state_q <= S_SW_BEGIN;
				end
				S_SW_BEGIN: begin
					n_q <= n_q + 1'b1;
					if (total_q != SW_MAX) begin
						total_q <= total_q + 1'b1;
					end
					i_q  <= kc;
					j_q  <= kc;
					ph_q <= '0;
					state_q <= (k2 > G_C) ? S_EN_START : S_SW_FETCH;
				end
				S_SW_FETCH: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd4) begin
						state_q <= S_SW_PUT;
					end
				end
				S_SW_PUT: begin
					ph_q <= '0;
					if (nx2 <= G_C) begin
						i_q     <= ipk;
						state_q <= S_SW_FETCH;
					end else if (ny2 <= G_C) begin
						i_q     <= kc;
						j_q     <= jpk;
						state_q <= S_SW_FETCH;
					end else begin
						state_q <= S_EN_START;
					end
				end
				S_EN_START: begin
					i_q   <= '0;
					j_q   <= '0;
					ph_q  <= '0;
					acc_q <= '0;
					state_q <= ((CW+1)'(kc) > G_C) ? S_EN_FIN : S_EN_FETCH;
				end
				S_EN_FETCH: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd4) begin
						ph_q    <= '0;
						state_q <= S_EN_MUL;
					end
				end
				S_EN_MUL: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd1 || ph_q == 3'd3) begin
						acc_q <= acc_q + ACC_W'(mul_q);
					end else if (ph_q == 3'd2 || ph_q == 3'd4) begin
						acc_q <= acc_q + (ACC_W'(mul_q) << 17);
					end
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						if (nx2 <= G_C) begin
							i_q     <= ipk;
							state_q <= S_EN_FETCH;
						end else if (ny2 <= G_C) begin
							i_q     <= '0;
							j_q     <= jpk;
							state_q <= S_EN_FETCH;
						end else begin
							state_q <= S_EN_FIN;
						end
					end
				end
				S_EN_FIN: begin
					s_q     <= s_next;
					ph_q    <= '0;
					state_q <= S_TEST;
				end
				S_TEST: begin
					ph_q <= ph_q + 1'b1;
					case (ph_q)
						3'd1:    prod_q <= 88'(mul_q);
						3'd2:    prod_q <= prod_q + (88'(mul_q) << 17);
						3'd3:    prod_q <= prod_q + (88'(mul_q) << 34);
						default: ;
					endcase
					if (ph_q == 3'd3) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (pass) begin
						state_q <= S_LVL_END;
					end else begin
						p_q <= s_q;
						if (n_q >= cap_q) begin
							conv_q  <= 1'b0;
							state_q <= S_LVL_END;
						end else begin
							state_q <= S_SW_BEGIN;
						end
					end
				end
				S_LVL_END: begin
					i_q  <= '0;
					j_q  <= '0;
					ph_q <= '0;
					if (lev_q == '0) begin
						energy_q <= s_q;
						rdsel_q  <= 1'b0;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if ((CW+1)'(kc) > G_C) begin
						lev_q   <= lev_q - 1'b1;
						state_q <= S_LEVEL;
					end else begin
						state_q <= S_RF_FETCH;
					end
				end
				S_RF_FETCH: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd4) begin
						ph_q    <= '0;
						state_q <= S_RF_PUT;
					end
				end
				S_RF_PUT: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						if (nx2 <= G_C) begin
							i_q     <= ipk;
							state_q <= S_RF_FETCH;
						end else if (ny2 <= G_C) begin
							i_q     <= '0;
							j_q     <= jpk;
							state_q <= S_RF_FETCH;
						end else begin
							lev_q   <= lev_q - 1'b1;
							state_q <= S_LEVEL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign node_value  = rdsel_q ? mem_rdata : '0;
	assign sweep_count = total_q;
	assign energy      = energy_q;
	assign converged   = conv_q;

endmodule

// ===== rtl/core/mglr_mul.sv =====
module mglr_mul (
	input  logic                           clk,
	input  mglr_pkg::mul_req_t             req,
	output logic [mglr_pkg::MUL_P_W-1:0]   prod
);
	import mglr_pkg::*;

	// One registered partial product per cycle.
	always_ff @(posedge clk) begin
		prod <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
	end

endmodule

// ===== rtl/core/mglr_mem.sv =====
module mglr_mem #(
	parameter int DEPTH = 16641,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	import mglr_pkg::*;

	logic [31:0] mem [DEPTH];

	// A read at the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/mglr_chk.sv =====
module mglr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  op,
	input logic        done,
	input logic [31:0] node_value,
	input logic [19:0] sweep_count
);
	import mglr_pkg::*;

	logic take;
	assign take = start && !busy;

	// A result is only strobed while the block is free for the next transfer.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobed while busy");

	// Node commands and unknown codes give their result in the next cycle.
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op != OP_SOLVE) |=> done) else $error("missing node result");

	// A solve holds the block in the cycle after its transfer.
	a_solve: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op == OP_SOLVE) |=> (busy && !done)) else $error("solve not started");

	// A node write reports zero.
	a_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op == OP_WRITE) |=> (node_value == '0)) else $error("write gave a value");

	// The sweep total changes only under a solve.
	a_sw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !(start && op == OP_SOLVE)) |=> $stable(sweep_count))
		else $error("sweep total changed outside a solve");

endmodule

bind multigrid_laplace_relaxation mglr_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.op(op),
	.done(done),
	.node_value(node_value),
	.sweep_count(sweep_count)
);

// ===== sim/multigrid_laplace_relaxation_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the multigrid Laplace relaxation block. Host commands
// (node write, solve, node read, unknown code) are queued by the stimulus
// process. A clocked driver feeds them to the block, and a clocked monitor
// predicts every result from its own copy of the grid and the registers.
// Solves on the full grid run long, so only a few solves are issued, each with
// a tiny sweep cap.
module multigrid_laplace_relaxation_test;
	import mglr_pkg::*;

	localparam int CELLS = 128;
	localparam int NODES = CELLS + 1;
	localparam longint CYCLE_LIMIT = 40_000_000;
	// The one op code that the block does not define.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic [7:0]         col;
		logic [7:0]         row;
		logic signed [31:0] value;
	} host_cmd_t;

	typedef struct {
		logic signed [31:0] node_value;
		logic [19:0]        sweep_count;
		logic [47:0]        energy;
		logic               converged;
	} host_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = OP_WRITE;
	logic [7:0] col = '0;
	logic [7:0] row = '0;
	logic signed [31:0] value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_TOL;
	logic [39:0] cfg_data = '0;
	logic done;
	logic signed [31:0] node_value;
	logic [19:0] sweep_count;
	logic [47:0] energy;
	logic converged;

	multigrid_laplace_relaxation #(.GRID_CELLS(CELLS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .col(col), .row(row), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .node_value(node_value), .sweep_count(sweep_count),
		.energy(energy), .converged(converged)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	host_cmd_t  cmd_q[$];
	host_resp_t resp_q[$];
	int errors = 0;
	int n_solves = 0, n_writes = 0, n_reads = 0, n_other = 0;
	bit gaps_on = 1'b1;
	bit took = 1'b0;
	longint cycles = 0;

	// Private copy of the block state and of its registers.
	logic signed [31:0] pgrid [NODES*NODES];
	logic [47:0] m_energy;
	logic [19:0] m_sweeps;
	logic        m_conv;
	logic [39:0] m_tol;
	logic [2:0]  m_coarse;
	logic [15:0] m_maxsw;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
	endtask

	function automatic longint nd(int i, int j);
		return longint'(pgrid[j*NODES + i]);
	endfunction

	// Interior nodes only; the edges are boundary values and never move.
	function automatic void put_node(int i, int j, longint v);
		if (i == 0 || j == 0 || i >= CELLS || j >= CELLS)
			return;
		pgrid[j*NODES + i] = v[31:0];
	endfunction

	function automatic logic [47:0] cell_energy(int k);
		logic [127:0] acc, sq, sh;
		longint a, b;
		logic [63:0] m;
		acc = '0;
		for (int j = 0; j + k <= CELLS; j += k)
			for (int i = 0; i + k <= CELLS; i += k) begin
				a = nd(i+k, j) - nd(i, j) + nd(i+k, j+k) - nd(i, j+k);
				b = nd(i, j+k) - nd(i, j) + nd(i+k, j+k) - nd(i+k, j);
				m = (a < 0) ? -a : a;
				sq = {64'd0, m} * {64'd0, m};
				acc += sq;
				m = (b < 0) ? -b : b;
				sq = {64'd0, m} * {64'd0, m};
				acc += sq;
			end
		sh = acc >> 31;
		return (sh > {80'd0, E48_MAX}) ? E48_MAX : sh[47:0];
	endfunction

	// Relative test |S - Sprev| * 2^40 < tol * Sprev, done exactly in 128 bits.
	function automatic bit settled(logic [47:0] s, logic [47:0] p);
		logic [127:0] d, lhs, rhs;
		d = (s > p) ? {80'd0, s - p} : {80'd0, p - s};
		lhs = d << 40;
		rhs = {88'd0, m_tol} * {80'd0, p};
		return lhs < rhs;
	endfunction

	function automatic void relax_solve();
		int k, h;
		int unsigned cap, n;
		logic [47:0] s, p;
		longint c00, c10, c01, c11;
		cap = (m_maxsw == 0) ? 1 : m_maxsw;
		s = '0;
		m_sweeps = '0;
		m_conv = 1'b1;
		for (int lev = m_coarse; lev >= 0; lev--) begin
			k = 1 << lev;
			p = {8'd0, m_tol} >> 12;
			n = 0;
			forever begin
				n++;
				if (m_sweeps != SW_MAX)
					m_sweeps++;
				for (int j = k; j + k <= CELLS; j += k)
					for (int i = k; i + k <= CELLS; i += k)
						put_node(i, j, (nd(i+k, j) + nd(i-k, j) + nd(i, j+k) + nd(i, j-k)) >>> 2);
				s = cell_energy(k);
				if (settled(s, p))
					break;
				p = s;
				if (n >= cap) begin
					m_conv = 1'b0;
					break;
				end
			end
			// Fill the half-step nodes by bilinear interpolation before the next level.
			if (k != 1) begin
				h = k / 2;
				for (int j = 0; j + k <= CELLS; j += k)
					for (int i = 0; i + k <= CELLS; i += k) begin
						c00 = nd(i, j);
						c10 = nd(i+k, j);
						c01 = nd(i, j+k);
						c11 = nd(i+k, j+k);
						put_node(i+h, j+h, (c00 + c10 + c01 + c11) >>> 2);
						put_node(i+k, j+h, (c10 + c11) >>> 1);
						put_node(i+h, j+k, (c01 + c11) >>> 1);
						put_node(i+h, j, (c00 + c10) >>> 1);
						put_node(i, j+h, (c00 + c01) >>> 1);
					end
			end
		end
		m_energy = s;
	endfunction

	function automatic host_resp_t predict_command(host_cmd_t c);
		host_resp_t r;
		bit in_grid;
		in_grid = (c.col <= CELLS) && (c.row <= CELLS);
		r.node_value = '0;
		if (c.op == OP_WRITE && in_grid)
			pgrid[c.row*NODES + c.col] = c.value;
		else if (c.op == OP_SOLVE)
			relax_solve();
		else if (c.op == OP_READ && in_grid)
			r.node_value = pgrid[c.row*NODES + c.col];
		r.sweep_count = m_sweeps;
		r.energy = m_energy;
		r.converged = m_conv;
		return r;
	endfunction

	// Monitor: checks the result strobe first, then predicts any command whose
	// transfer happens at this edge, so the expectation order follows the block.
	always @(posedge clk) begin
		host_resp_t want;
		host_cmd_t c;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycles);
			$display("multigrid_laplace_relaxation_test: done, errors");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (resp_q.size() == 0) begin
					report("unexpected result", {32'd0, node_value}, '0);
				end else begin
					want = resp_q.pop_front();
					if (node_value !== want.node_value)
						report("node_value", {32'd0, node_value}, {32'd0, want.node_value});
					if (sweep_count !== want.sweep_count)
						report("sweep_count", {44'd0, sweep_count}, {44'd0, want.sweep_count});
					if (energy !== want.energy)
						report("energy", {16'd0, energy}, {16'd0, want.energy});
					if (converged !== want.converged)
						report("converged", {63'd0, converged}, {63'd0, want.converged});
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOL: m_tol = cfg_data;
					REG_COARSE: m_coarse = cfg_data[2:0];
					REG_MAXSW: m_maxsw = cfg_data[15:0];
					default: ;
				endcase
			end
			took = start && !busy;
			if (took) begin
				c.op = op;
				c.col = col;
				c.row = row;
				c.value = value;
				resp_q.push_back(predict_command(c));
			end
		end
	end

	// Driver: a command stays on the ports until its transfer, then the next one
	// is taken from the queue, with random idle bursts while gaps are enabled.
	int gap = 0;
	always @(negedge clk) begin
		host_cmd_t c;
		if (!arst_n || (start && !took)) begin
			// Hold the current command, or keep quiet during reset.
		end else if (gap > 0) begin
			gap <= gap - 1;
			start <= 1'b0;
		end else if (cmd_q.size() == 0) begin
			start <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap <= $urandom_range(0, 11);
			start <= 1'b0;
		end else begin
			c = cmd_q.pop_front();
			op <= c.op;
			col <= c.col;
			row <= c.row;
			value <= c.value;
			start <= 1'b1;
			case (c.op)
				OP_WRITE: n_writes++;
				OP_SOLVE: n_solves++;
				OP_READ: n_reads++;
				default: n_other++;
			endcase
		end
	end

	task automatic queue_cmd(logic [1:0] o, logic [7:0] cl, logic [7:0] rw, logic [31:0] v);
		host_cmd_t c;
		c.op = o;
		c.col = cl;
		c.row = rw;
		c.value = v;
		cmd_q.push_back(c);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Idle means nothing queued, nothing on the ports and nothing outstanding.
	task automatic wait_idle();
		@(posedge clk);
		while (cmd_q.size() != 0 || start || resp_q.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly in-range nodes; now and then any index at all, so every bit toggles.
	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, CELLS));
	endfunction

	task automatic random_batch(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				queue_cmd(OP_WRITE, pick_index(), pick_index(), $urandom);
			else if (pick < 95)
				queue_cmd(OP_READ, pick_index(), pick_index(), $urandom);
			else
				queue_cmd(OP_UNKNOWN, pick_index(), pick_index(), $urandom);
		end
	endtask

	initial begin
		foreach (pgrid[n])
			pgrid[n] = '0;
		m_energy = '0;
		m_sweeps = '0;
		m_conv = 1'b0;
		m_tol = TOL_RST;
		m_coarse = COARSE_RST;
		m_maxsw = MAXSW_RST;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		// The block clears its grid after reset; the registers wait for that.
		wait_idle();

		// First setting: zero cap (one sweep per level) and the coarsest start step,
		// which is the whole grid, so the first level relaxes nothing.
		write_reg(REG_MAXSW, 40'd0);
		write_reg(REG_COARSE, 40'd7);

		// Directed commands: edge extremes, out-of-range indexes, the unknown code.
		queue_cmd(OP_WRITE, 8'd0, 8'd0, 32'h7FFF_FFFF);
		queue_cmd(OP_WRITE, 8'd128, 8'd128, 32'h8000_0000);
		queue_cmd(OP_WRITE, 8'd128, 8'd0, 32'h1000_0000);
		queue_cmd(OP_WRITE, 8'd0, 8'd128, 32'hF000_0000);
		queue_cmd(OP_WRITE, 8'd64, 8'd0, 32'hFFFF_FFFF);
		queue_cmd(OP_WRITE, 8'd0, 8'd64, 32'h0000_0001);
		queue_cmd(OP_WRITE, 8'd129, 8'd5, 32'h1234_5678);
		queue_cmd(OP_WRITE, 8'd5, 8'd255, 32'h1234_5678);
		queue_cmd(OP_WRITE, 8'd64, 8'd64, 32'h5555_AAAA);
		queue_cmd(OP_READ, 8'd0, 8'd0, 32'd0);
		queue_cmd(OP_READ, 8'd128, 8'd128, 32'd0);
		queue_cmd(OP_READ, 8'd129, 8'd5, 32'd0);
		queue_cmd(OP_READ, 8'd255, 8'd255, 32'hFFFF_FFFF);
		queue_cmd(OP_UNKNOWN, 8'd1, 8'd1, 32'hFFFF_FFFF);
		queue_cmd(OP_READ, 8'd64, 8'd64, 32'd0);
		queue_cmd(OP_SOLVE, 8'd0, 8'd0, 32'd0);
		queue_cmd(OP_READ, 8'd64, 8'd64, 32'd0);
		queue_cmd(OP_READ, 8'd1, 8'd1, 32'd0);
		queue_cmd(OP_UNKNOWN, 8'd0, 8'd0, 32'd0);
		wait_idle();

		// Second setting: widest tolerance, finest start step, a cap of two sweeps per level.
		write_reg(REG_TOL, 40'hFF_FFFF_FFFF);
		write_reg(REG_COARSE, 40'd0);
		write_reg(REG_MAXSW, 40'd2);
		random_batch(280);
		queue_cmd(OP_SOLVE, 8'($urandom), 8'($urandom), $urandom);
		random_batch(20);
		wait_idle();

		// Third setting: zero tolerance, so no level can settle; one sweep each.
		write_reg(REG_TOL, 40'd0);
		write_reg(REG_COARSE, 40'd3);
		write_reg(REG_MAXSW, 40'd1);
		random_batch(180);
		queue_cmd(OP_SOLVE, 8'($urandom), 8'($urandom), $urandom);
		random_batch(20);
		wait_idle();
		// The tail of the run goes back to back, with no idle cycles.
		gaps_on = 1'b0;
		random_batch(100);
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Covered %0d node writes, %0d node reads, %0d unknown commands, %0d solves",
			n_writes, n_reads, n_other, n_solves);
		$display("over three register settings, including zero cap and coarsest/finest step.");
		if (errors == 0)
			$display("multigrid_laplace_relaxation_test: done, clean");
		else
			$display("multigrid_laplace_relaxation_test: done, errors");
		$finish;
	end

endmodule
